@@ sv/pprl_pkg.sv @@
// Shared types, codes and reset constants of the per-peer rate limiter.
// Self-contained; imported by pprl_eval and the top level.
package pprl_pkg;

    localparam int PEER_SLOTS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int SLOT_W     = 5;
    localparam int TYPE_W     = 8;
    localparam int TIME_W     = 32;
    localparam int VIOL_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic FUNC_MSG   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [TYPE_W-1:0] TYPE_TX = 8'h05;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MSG  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIOL_LIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAN_SECS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_SECS = 3'd4;

    localparam logic [15:0]       MAX_MSG_RST  = 16'd100;
    localparam logic [15:0]       MAX_TX_RST   = 16'd50;
    localparam logic [VIOL_W-1:0] VIOL_LIM_RST = 8'd5;
    localparam logic [31:0]       BAN_SECS_RST = 32'd3600;
    localparam logic [15:0]       WIN_SECS_RST = 16'd60;

    typedef enum logic [2:0] {
        V_ACCEPT   = 3'd0,
        V_BANNED   = 3'd1,
        V_MSG_RATE = 3'd2,
        V_TX_RATE  = 3'd3,
        V_UNKNOWN  = 3'd4,
        V_CLEARED  = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_TEMP_BAN = 2'd1,
        ACT_PERM_BAN = 2'd2
    } t_action;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic [TYPE_W-1:0] msg_type;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [15:0]       max_msg;
        logic [15:0]       max_tx;
        logic [VIOL_W-1:0] viol_limit;
        logic [31:0]       ban_secs;
        logic [15:0]       win_secs;
    } t_cfg;

    // ban/window part of a peer record; counters live in their own memory
    typedef struct packed {
        logic [TIME_W-1:0] window_end;
        logic              banned;
        logic [TIME_W-1:0] ban_expiry;   // zero = permanent
        logic [VIOL_W-1:0] violations;
    } t_ban_rec;

    typedef struct packed {
        t_verdict          verdict;
        t_action           action;
        logic              unbanned;
        logic [TYPE_W-1:0] dispatch;
    } t_result;

    function automatic logic known_type(input logic [TYPE_W-1:0] t);
        return t inside {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd7, 8'd8};
    endfunction

endpackage

@@ sv/pprl_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module pprl_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/pprl_eval.sv @@
// Two-stage evaluation of one item against its peer record: window/ban
// prep into registers, then limit checks and write-back record. Uses pprl_pkg.
module pprl_eval #(
    parameter int CB = 16
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  pprl_pkg::t_item   i_item,
    input  logic              i_slot_ok,
    input  pprl_pkg::t_cfg    i_cfg,
    input  pprl_pkg::t_ban_rec i_rd_ban,
    input  logic [CB-1:0]     i_rd_msg,
    input  logic [CB-1:0]     i_rd_tx,
    output logic              o_wr,
    output pprl_pkg::t_ban_rec o_wr_ban,
    output logic [CB-1:0]     o_wr_msg,
    output logic [CB-1:0]     o_wr_tx,
    output pprl_pkg::t_result o_result
);
    import pprl_pkg::*;

    // stage 1 (combinational from read data)
    logic              blocked, unban, win_exp;
    logic [TIME_W:0]   win_sum, ban_sum;
    logic [TIME_W-1:0] new_end, ban_end;
    logic [CB-1:0]     msg_base, tx_base, msg_new, tx_inc;
    logic [VIOL_W-1:0] viol_base;

    // stage 1 registers
    logic              r_blocked, r_unban, r_win_exp;
    logic [TIME_W-1:0] r_new_end, r_ban_end;
    logic [CB-1:0]     r_msg_new, r_tx_base, r_tx_inc;
    logic [VIOL_W-1:0] r_viol_base;
    t_ban_rec          r_old;

    // stage 2
    logic              msg_over, tx_over, is_tx, known, hit;
    logic [VIOL_W-1:0] viol_inc;

    always_comb begin
        blocked = i_rd_ban.banned &&
                  !(i_rd_ban.ban_expiry != '0 && i_item.now >= i_rd_ban.ban_expiry);
        unban   = i_rd_ban.banned && !blocked;
        win_exp = i_item.now >= i_rd_ban.window_end;
        win_sum = {1'b0, i_item.now} + (TIME_W+1)'(i_cfg.win_secs);
        new_end = win_sum[TIME_W] ? '1 : win_sum[TIME_W-1:0];
        ban_sum = {1'b0, i_item.now} + {1'b0, i_cfg.ban_secs};
        ban_end = ban_sum[TIME_W] ? '1 : ban_sum[TIME_W-1:0];
        if (ban_end == '0) begin
            ban_end = TIME_W'(1);   // keep the ban temporary
        end
        msg_base  = win_exp ? '0 : i_rd_msg;
        tx_base   = win_exp ? '0 : i_rd_tx;
        msg_new   = (msg_base == '1) ? msg_base : msg_base + CB'(1);
        tx_inc    = (tx_base == '1) ? tx_base : tx_base + CB'(1);
        viol_base = unban ? '0 : i_rd_ban.violations;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_blocked   <= blocked;
            r_unban     <= unban;
            r_win_exp   <= win_exp;
            r_new_end   <= new_end;
            r_ban_end   <= ban_end;
            r_msg_new   <= msg_new;
            r_tx_base   <= tx_base;
            r_tx_inc    <= tx_inc;
            r_viol_base <= viol_base;
            r_old       <= i_rd_ban;
        end
    end

    always_comb begin
        is_tx    = i_item.msg_type == TYPE_TX;
        known    = known_type(i_item.msg_type);
        msg_over = 33'(r_msg_new) > 33'(i_cfg.max_msg);
        tx_over  = is_tx && (33'(r_tx_inc) > 33'(i_cfg.max_tx));
        viol_inc = (r_viol_base == '1) ? r_viol_base : r_viol_base + VIOL_W'(1);
        hit      = viol_inc >= i_cfg.viol_limit;

        o_wr     = 1'b0;
        o_wr_ban = '0;
        o_wr_msg = '0;
        o_wr_tx  = '0;
        o_result = '{verdict: V_ACCEPT, action: ACT_NONE, unbanned: 1'b0, dispatch: '0};

        if (i_item.func == FUNC_CLEAR) begin
            o_wr = i_slot_ok;
            o_result.verdict = V_CLEARED;
        end else if (!i_slot_ok || r_blocked) begin
            o_result.verdict = V_BANNED;
        end else begin
            o_wr                = 1'b1;
            o_result.unbanned   = r_unban;
            o_wr_msg            = r_msg_new;
            o_wr_tx             = r_tx_base;
            o_wr_ban.window_end = r_win_exp ? r_new_end : r_old.window_end;
            o_wr_ban.banned     = 1'b0;
            o_wr_ban.ban_expiry = r_old.ban_expiry;
            o_wr_ban.violations = r_viol_base;
            if (msg_over) begin
                o_result.verdict    = V_MSG_RATE;
                o_wr_ban.violations = viol_inc;
                if (hit) begin
                    o_wr_ban.banned     = 1'b1;
                    o_wr_ban.ban_expiry = r_ban_end;
                    o_result.action     = ACT_TEMP_BAN;
                end
            end else if (tx_over) begin
                o_result.verdict    = V_TX_RATE;
                o_wr_tx             = r_tx_inc;
                o_wr_ban.violations = viol_inc;
            end else begin
                if (is_tx) begin
                    o_wr_tx = r_tx_inc;
                end
                if (known) begin
                    o_result.dispatch = i_item.msg_type;
                end else begin
                    o_result.verdict    = V_UNKNOWN;
                    o_wr_ban.violations = viol_inc;
                    if (hit) begin
                        o_wr_ban.banned     = 1'b1;
                        o_wr_ban.ban_expiry = '0;
                        o_result.action     = ACT_PERM_BAN;
                    end
                end
            end
        end
    end
endmodule

@@ sv/per_peer_rate_limit_ban_policy.sv @@
// Per-peer fixed-window rate limiter with violation bans, top level.
// o_done is registered and rises after the accepting edge, the prep state and the decide state.
// Items are handled one at a time (accept, prep, decide/write-back); sequential use.
// Reset: synchronous, active low; then a clearing pass over all PEER_SLOTS entries zeroes the
// record memories, busy held high meanwhile. Results cannot be stalled by the receiver.
// Depends on pprl_pkg, pprl_ram, pprl_eval.
module per_peer_rate_limit_ban_policy #(
    parameter int PEER_SLOTS = pprl_pkg::PEER_SLOTS_DEF,
    parameter int COUNT_BITS = pprl_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [pprl_pkg::SLOT_W-1:0]         i_peer_slot,
    input  logic [pprl_pkg::TYPE_W-1:0]         i_msg_type,
    input  logic [pprl_pkg::TIME_W-1:0]         i_now_time,
    input  logic                                i_cfg_we,
    input  logic [pprl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pprl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_done,
    output logic [2:0]                          o_verdict,
    output logic [1:0]                          o_ban_action,
    output logic                                o_was_unbanned,
    output logic [pprl_pkg::TYPE_W-1:0]         o_dispatch_type
);
    import pprl_pkg::*;

    localparam int AW    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int EXT_W = SLOT_W + AW + 1;
    localparam int BAN_W = $bits(t_ban_rec);

    // one-hot sequencer: sweep after reset, idle, prep, decide/write-back
    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_CALC = 4'b0100,
        ST_DEC  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic [AW-1:0]   r_addr;
    logic            r_slot_ok;
    t_item           r_item;
    t_cfg            r_cfg;
    logic            r_done;
    t_result         r_res;

    logic            accept;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_ban_rec        ban_wdata, rd_ban, ev_ban;
    logic [COUNT_BITS-1:0] msg_wdata, tx_wdata, rd_msg, rd_tx, ev_msg, ev_tx;
    logic [BAN_W-1:0] rd_ban_raw;
    logic            ev_wr;
    t_result         ev_res;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLR:  begin
                if (r_clr_addr == AW'(PEER_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_DEC;
            ST_DEC:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_DEC);
            if (r_state == ST_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // item capture; held through prep and decide
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= '{func: i_func, slot: i_peer_slot, msg_type: i_msg_type,
                           now: i_now_time};
            r_addr    <= AW'(i_peer_slot);
            r_slot_ok <= EXT_W'(i_peer_slot) < EXT_W'(PEER_SLOTS);
        end
        if (r_state == ST_DEC) begin
            r_res <= ev_res;
        end
    end

    // ---------------- config registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{max_msg: MAX_MSG_RST, max_tx: MAX_TX_RST, viol_limit: VIOL_LIM_RST,
                       ban_secs: BAN_SECS_RST, win_secs: WIN_SECS_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_MSG:  r_cfg.max_msg    <= i_cfg_wdata[15:0];
                CFG_MAX_TX:   r_cfg.max_tx     <= i_cfg_wdata[15:0];
                CFG_VIOL_LIM: r_cfg.viol_limit <= i_cfg_wdata[VIOL_W-1:0];
                CFG_BAN_SECS: r_cfg.ban_secs   <= i_cfg_wdata[31:0];
                CFG_WIN_SECS: r_cfg.win_secs   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- record memories ----------------
    // Single item in flight, so read and write-back of a slot never overlap.
    assign mem_we    = (r_state == ST_CLR) || ((r_state == ST_DEC) && ev_wr);
    assign mem_waddr = (r_state == ST_CLR) ? r_clr_addr : r_addr;
    assign ban_wdata = (r_state == ST_CLR) ? '0 : ev_ban;
    assign msg_wdata = (r_state == ST_CLR) ? '0 : ev_msg;
    assign tx_wdata  = (r_state == ST_CLR) ? '0 : ev_tx;

    pprl_ram #(.W(BAN_W), .DEPTH(PEER_SLOTS), .AW(AW)) u_ban_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (ban_wdata),
        .i_re    (accept),
        .i_raddr (AW'(i_peer_slot)),
        .o_rdata (rd_ban_raw)
    );
    assign rd_ban = t_ban_rec'(rd_ban_raw);

    pprl_ram #(.W(2*COUNT_BITS), .DEPTH(PEER_SLOTS), .AW(AW)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({msg_wdata, tx_wdata}),
        .i_re    (accept),
        .i_raddr (AW'(i_peer_slot)),
        .o_rdata ({rd_msg, rd_tx})
    );

    // ---------------- evaluation ----------------
    pprl_eval #(.CB(COUNT_BITS)) u_eval (
        .i_clk     (i_clk),
        .i_load    (r_state == ST_CALC),
        .i_item    (r_item),
        .i_slot_ok (r_slot_ok),
        .i_cfg     (r_cfg),
        .i_rd_ban  (rd_ban),
        .i_rd_msg  (rd_msg),
        .i_rd_tx   (rd_tx),
        .o_wr      (ev_wr),
        .o_wr_ban  (ev_ban),
        .o_wr_msg  (ev_msg),
        .o_wr_tx   (ev_tx),
        .o_result  (ev_res)
    );

    // ---------------- result port ----------------
    assign o_done          = r_done;
    assign o_verdict       = r_res.verdict;
    assign o_ban_action    = r_res.action;
    assign o_was_unbanned  = r_res.unbanned;
    assign o_dispatch_type = r_res.dispatch;

`ifndef NO_ASSERTIONS
    a_done_after_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_DEC))
        else $error("result strobe without a decide cycle");

    a_accept_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CALC))
        else $error("accepted item did not enter prep");

    a_no_write_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> !mem_we)
        else $error("record write while the read data is in use");

    a_dispatch_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_verdict != V_ACCEPT) |-> (o_dispatch_type == '0))
        else $error("dispatch type on a dropped item");

    a_ban_needs_violation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ban_action != ACT_NONE) |->
        (o_verdict == V_MSG_RATE || o_verdict == V_UNKNOWN))
        else $error("ban imposed without a rate or type violation");
`endif
endmodule
